[hw/rtl/pps_pkg.sv]
// Shared types and constants for the preemptive priority scheduler.
package pps_pkg;

    localparam int TASK_SLOTS = 16;
    localparam int SLOT_W     = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
    localparam int CNT_W      = $clog2(TASK_SLOTS + 1);

    localparam logic KIND_LOAD = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    localparam logic [1:0] STATUS_RAN  = 2'd0;
    localparam logic [1:0] STATUS_IDLE = 2'd1;
    localparam logic [1:0] STATUS_DONE = 2'd2;

    localparam logic [15:0] TIME_MAX = 16'hFFFF;

    typedef struct packed {
        logic        kind;
        logic [15:0] task_id;
        logic [15:0] arrival_time;
        logic [15:0] work_units;
        logic [7:0]  task_priority;
    } t_in;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] run_id;
        logic [7:0]  run_priority;
        logic [15:0] units_left;
        logic        preempted;
        logic [15:0] preempted_id;
        logic [15:0] tick_time;
    } t_out;

    typedef struct packed {
        logic [15:0] id;
        logic [15:0] arrival;
        logic [15:0] work;
        logic [7:0]  prio;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[hw/rtl/pps_ram.sv]
// Generic single-port RAM with registered read.
module pps_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  logic                             i_clk,
    input  logic                             i_we,
    input  logic [$clog2(DEPTH)-1:0]         i_addr,
    input  logic [WIDTH-1:0]                 i_wdata,
    output logic [WIDTH-1:0]                 o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

[hw/rtl/preemptive_priority_scheduler_top.sv]
// Preemptive priority scheduler top level: task table RAM, tick scan sequencer, output register.
// Load: accepted while idle, no result. Tick: one table read per loaded slot plus a read drain,
// then, if a task is ready, a read of the last-run entry (S_PREV, S_PCHK) and the output and
// write-back state S_OUT; with none ready the scan ends in S_OUT; an empty table skips the scan.
// One item is in work at a time; the next can be taken in the cycle its result first shows valid.
// Synchronous active-low reset clears count, time, last-run state and the sequencer.
module preemptive_priority_scheduler_top import pps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_in  i_data,
    output logic o_valid,
    input  logic i_stall,
    output t_out o_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_SCAN = 5'b00010,
        S_PREV = 5'b00100,
        S_PCHK = 5'b01000,
        S_OUT  = 5'b10000
    } t_state;

    t_state              r_state, n_state;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [15:0]         r_time, n_time;
    logic [SLOT_W-1:0]   r_last_slot, n_last_slot;
    logic                r_last_valid, n_last_valid;
    logic [CNT_W-1:0]    r_idx, n_idx;
    logic                r_pend, n_pend;
    logic [SLOT_W-1:0]   r_pslot, n_pslot;
    logic                r_found, n_found;
    logic                r_any, n_any;
    logic [SLOT_W-1:0]   r_best_slot, n_best_slot;
    t_entry              r_best, n_best;
    logic                r_preempt, n_preempt;
    logic [15:0]         r_pid, n_pid;
    logic                r_out_valid, n_out_valid;
    t_out                r_out, n_out;

    logic                ram_we;
    logic [SLOT_W-1:0]   ram_addr;
    t_entry              ram_wdata;
    logic [ENTRY_W-1:0]  ram_rdata;
    t_entry              rd_entry;
    logic                in_xfer;
    logic                issue;

    pps_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(TASK_SLOTS)
    ) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_addr (ram_addr),
        .i_wdata(ram_wdata),
        .o_rdata(ram_rdata)
    );

    assign rd_entry = t_entry'(ram_rdata);
    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign o_valid  = r_out_valid;
    assign o_data   = r_out;

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_time       = r_time;
        n_last_slot  = r_last_slot;
        n_last_valid = r_last_valid;
        n_idx        = r_idx;
        n_pend       = r_pend;
        n_pslot      = r_pslot;
        n_found      = r_found;
        n_any        = r_any;
        n_best_slot  = r_best_slot;
        n_best       = r_best;
        n_preempt    = r_preempt;
        n_pid        = r_pid;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        ram_we       = 1'b0;
        ram_addr     = r_count[SLOT_W-1:0];
        ram_wdata.id      = i_data.task_id;
        ram_wdata.arrival = i_data.arrival_time;
        ram_wdata.work    = i_data.work_units;
        ram_wdata.prio    = i_data.task_priority;
        issue        = 1'b0;

        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_data.kind == KIND_LOAD) begin
                        if (r_count < CNT_W'(TASK_SLOTS)) begin
                            ram_we  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end else begin
                        n_idx     = '0;
                        n_pend    = 1'b0;
                        n_found   = 1'b0;
                        n_any     = 1'b0;
                        n_preempt = 1'b0;
                        n_pid     = '0;
                        n_state   = (r_count == '0) ? S_OUT : S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                ram_addr = r_idx[SLOT_W-1:0];
                issue    = (r_idx < r_count);
                n_pend   = issue;
                n_pslot  = r_idx[SLOT_W-1:0];
                if (issue) begin
                    n_idx = r_idx + CNT_W'(1);
                end
                if (r_pend && rd_entry.work != '0) begin
                    n_any = 1'b1;
                    if (rd_entry.arrival <= r_time &&
                        (!r_found || rd_entry.prio < r_best.prio)) begin
                        n_found     = 1'b1;
                        n_best_slot = r_pslot;
                        n_best      = rd_entry;
                    end
                end
                if (!issue && !r_pend) begin
                    n_state = r_found ? S_PREV : S_OUT;
                end
            end
            S_PREV: begin
                ram_addr = r_last_slot;
                n_state  = S_PCHK;
            end
            S_PCHK: begin
                n_preempt = r_last_valid && (r_last_slot != r_best_slot) &&
                            (rd_entry.work != '0);
                n_pid     = n_preempt ? rd_entry.id : 16'd0;
                n_state   = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || !i_stall) begin
                    n_out_valid = 1'b1;
                    n_out       = '0;
                    n_out.tick_time = r_time;
                    if (r_found) begin
                        ram_we             = 1'b1;
                        ram_addr           = r_best_slot;
                        ram_wdata          = r_best;
                        ram_wdata.work     = r_best.work - 16'd1;
                        n_out.status       = STATUS_RAN;
                        n_out.run_id       = r_best.id;
                        n_out.run_priority = r_best.prio;
                        n_out.units_left   = r_best.work - 16'd1;
                        n_out.preempted    = r_preempt;
                        n_out.preempted_id = r_pid;
                        n_last_slot        = r_best_slot;
                        n_last_valid       = 1'b1;
                    end else begin
                        n_out.status = r_any ? STATUS_IDLE : STATUS_DONE;
                    end
                    if (r_time != TIME_MAX) begin
                        n_time = r_time + 16'd1;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_count      <= '0;
            r_time       <= '0;
            r_last_slot  <= '0;
            r_last_valid <= 1'b0;
            r_pend       <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_count      <= n_count;
            r_time       <= n_time;
            r_last_slot  <= n_last_slot;
            r_last_valid <= n_last_valid;
            r_pend       <= n_pend;
            r_out_valid  <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx       <= n_idx;
        r_pslot     <= n_pslot;
        r_found     <= n_found;
        r_any       <= n_any;
        r_best_slot <= n_best_slot;
        r_best      <= n_best;
        r_preempt   <= n_preempt;
        r_pid       <= n_pid;
        r_out       <= n_out;
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(TASK_SLOTS))
        else $error("loaded count past table size");

    a_scan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (r_idx <= r_count))
        else $error("scan index past loaded count");

    a_preempt_ran: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_data.preempted) |-> (o_data.status == STATUS_RAN))
        else $error("preemption flagged without a task run");

    a_time_mono: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_time >= $past(r_time)))
        else $error("time counter moved backward");

endmodule

[tb/schedule_checker.sv]
// Scheduler checker: predicts the result of each tick transfer and compares it on the output.
`timescale 1ns / 100ps
module schedule_checker import pps_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_in_stall,
    input  t_in  i_in_data,
    input  logic i_out_valid,
    input  logic i_out_stall,
    input  t_out i_out_data,
    output int   o_errors,
    output int   o_pending
);

    t_entry      task_slots [TASK_SLOTS];
    int          fill_count;
    logic [15:0] clock_now;
    int          last_ran;
    bit          ran_once;
    t_out        tick_results_q [$];

    function automatic t_out schedule_tick();
        t_out res;
        int   s;
        int   pick;
        bit   ready;
        bit   work_left;
        res       = '0;
        pick      = 0;
        ready     = 1'b0;
        work_left = 1'b0;
        res.tick_time = clock_now;
        for (s = 0; s < fill_count; s++) begin
            if (task_slots[s].work != 16'd0) begin
                work_left = 1'b1;
                if (task_slots[s].arrival <= clock_now &&
                    (!ready || task_slots[s].prio < task_slots[pick].prio)) begin
                    pick  = s;
                    ready = 1'b1;
                end
            end
        end
        if (ready) begin
            if (ran_once && last_ran != pick && task_slots[last_ran].work != 16'd0) begin
                res.preempted    = 1'b1;
                res.preempted_id = task_slots[last_ran].id;
            end
            task_slots[pick].work = task_slots[pick].work - 16'd1;
            res.status       = STATUS_RAN;
            res.run_id       = task_slots[pick].id;
            res.run_priority = task_slots[pick].prio;
            res.units_left   = task_slots[pick].work;
            last_ran = pick;
            ran_once = 1'b1;
        end else begin
            res.status = work_left ? STATUS_IDLE : STATUS_DONE;
        end
        if (clock_now != TIME_MAX) clock_now = clock_now + 16'd1;
        return res;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_out want;
        if (!i_rst_n) begin
            fill_count = 0;
            clock_now  = '0;
            last_ran   = 0;
            ran_once   = 1'b0;
            o_errors   = 0;
            tick_results_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (tick_results_q.size() == 0) begin
                    if (o_errors < 10)
                        $display("%0t: result transfer with none expected: %p",
                                 $time, i_out_data);
                    o_errors++;
                end else begin
                    want = tick_results_q.pop_front();
                    if (i_out_data.status       !== want.status       ||
                        i_out_data.run_id       !== want.run_id       ||
                        i_out_data.run_priority !== want.run_priority ||
                        i_out_data.units_left   !== want.units_left   ||
                        i_out_data.preempted    !== want.preempted    ||
                        i_out_data.preempted_id !== want.preempted_id ||
                        i_out_data.tick_time    !== want.tick_time) begin
                        if (o_errors < 10) begin
                            $display("%0t: mismatch, expected %p", $time, want);
                            $display("%0t:           actual   %p", $time, i_out_data);
                        end
                        o_errors++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_in_data.kind == KIND_TICK) begin
                    tick_results_q.push_back(schedule_tick());
                end else if (fill_count < TASK_SLOTS) begin
                    task_slots[fill_count].id      = i_in_data.task_id;
                    task_slots[fill_count].arrival = i_in_data.arrival_time;
                    task_slots[fill_count].work    = i_in_data.work_units;
                    task_slots[fill_count].prio    = i_in_data.task_priority;
                    fill_count++;
                end
            end
        end
        o_pending <= tick_results_q.size();
    end

endmodule

[tb/tb.sv]
// Scheduler testbench top: drives load and tick transfers, stalls the output, gives the verdict.
`timescale 1ns / 100ps
module tb import pps_pkg::*; ();

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic in_valid  = 1'b0;
    logic in_stall;
    t_in  in_data   = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_out out_data;
    int   errors;
    int   pending;
    int   tx_idle    = 27;
    int   rx_idle    = 84;
    int   ticks_sent = 0;
    int   loads_sent = 0;

    preemptive_priority_scheduler_top DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_valid (in_valid),
        .o_stall (in_stall),
        .i_data  (in_data),
        .o_valid (out_valid),
        .i_stall (out_stall),
        .o_data  (out_data)
    );

    schedule_checker CHK (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_in_data   (in_data),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_out_data  (out_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        out_stall <= ($urandom_range(0, 99) < rx_idle);
    end

    // tick transfers carry random content in the unused fields
    function automatic t_in tick_item();
        t_in it;
        it.kind          = KIND_TICK;
        it.task_id       = 16'($urandom);
        it.arrival_time  = 16'($urandom);
        it.work_units    = 16'($urandom);
        it.task_priority = 8'($urandom);
        return it;
    endfunction

    function automatic t_in load_item(logic [15:0] id, logic [15:0] arrival,
                                      logic [15:0] work, logic [7:0] prio);
        t_in it;
        it.kind          = KIND_LOAD;
        it.task_id       = id;
        it.arrival_time  = arrival;
        it.work_units    = work;
        it.task_priority = prio;
        return it;
    endfunction

    // arrivals mostly land ahead of the current tick so tasks keep showing up
    function automatic t_in random_item();
        t_in it;
        int  roll;
        int  horizon;
        it   = tick_item();
        roll = $urandom_range(0, 99);
        if (roll < ((loads_sent < TASK_SLOTS) ? 15 : 4)) begin
            it.kind = KIND_LOAD;
            roll = $urandom_range(0, 9);
            if (roll < 8)      horizon = ticks_sent + $urandom_range(0, 1000);
            else if (roll < 9) horizon = $urandom_range(0, ticks_sent);
            else               horizon = $urandom_range(0, 65535);
            it.arrival_time = (horizon > 65535) ? 16'hFFFF : horizon[15:0];
            roll = $urandom_range(0, 9);
            if (roll < 6)      it.work_units = 16'($urandom_range(1, 200));
            else if (roll < 8) it.work_units = 16'($urandom_range(1, 8));
            else if (roll < 9) it.work_units = 16'd0;
            else               it.work_units = 16'($urandom);
            if ($urandom_range(0, 9) < 7) it.task_priority = 8'($urandom_range(0, 7));
        end
        return it;
    endfunction

    task automatic send(input t_in item);
        while ($urandom_range(0, 99) < tx_idle) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do @(posedge clk); while (in_stall);
        if (item.kind == KIND_TICK) ticks_sent++;
        else loads_sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    // loads into a full table are dropped and not counted
    task automatic random_items(input int count);
        int   taken;
        t_in  item;
        taken = 0;
        while (taken < count) begin
            item = random_item();
            if (item.kind == KIND_TICK || loads_sent < TASK_SLOTS) taken++;
            send(item);
        end
    endtask

    initial begin
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send(tick_item());
        send(load_item(16'hFFFF, 16'h0000, 16'd2,    8'hFF));
        send(load_item(16'h0000, 16'hFFFF, 16'hFFFF, 8'h00));
        send(load_item(16'h1234, 16'h0000, 16'd0,    8'h00));
        send(tick_item());
        send(load_item(16'h0005, 16'd3,    16'd3,    8'h80));
        send(tick_item());
        send(tick_item());
        send(load_item(16'h00AA, 16'h0000, 16'd2,    8'h10));
        send(load_item(16'h00BB, 16'h0000, 16'd1,    8'h10));
        repeat (6) send(tick_item());
        drain();

        random_items(480);
        drain();
        tx_idle = 84;
        rx_idle = 27;
        random_items(480);
        drain();
        tx_idle = 0;
        rx_idle = 0;
        random_items(490);
        drain();
        repeat (40) @(posedge clk);

        if (errors == 0) $display("TEST PASSED");
        else $display("TEST FAILED");
        $finish;
    end

    initial begin
        #100_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

[sim.f]
hw/rtl/pps_pkg.sv
hw/rtl/pps_ram.sv
hw/rtl/preemptive_priority_scheduler_top.sv
tb/schedule_checker.sv
tb/tb.sv
